// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int LEN_POS = 56;
	localparam int HASH_WORDS = 8;
	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        digest_done;
	} out_item_t;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PAD   = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_ROUND = 7'b0001000,
		ST_FOLD  = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== sv/sha256_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-stream SHA-256: buffers bytes in a word memory, compresses each block
// with one round per cycle and emits the eight digest words on message end.
// ----------------------------------------------------------------------------
// channel  direction  payload      transfer
// in       in         in_item_t    in_valid & in_ready
// out      out        out_item_t   out_valid & out_ready
//
// A byte that does not complete a block is taken in the idle state. A byte that
// completes a block holds the input through the load, round and fold passes,
// set by the registered reads of the memories and the shared
// round unit. A last item adds one or two padded blocks, each with a pad pass,
// then eight output transfers, each through the wait state and the emit state.
// Output stalls hold the emit state.
// Reset restores the initial chaining words; the block memory is not cleared.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sha_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sha_pkg::out_item_t  out_data
);
	import sha_pkg::*;

	// block memory: 16 big-endian words, bytes gathered in part_q and written as whole words
	logic [31:0] blk_mem [16];
	logic [31:0] rd_word_q;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_word;

	// chaining memory: 8 words
	logic [31:0] chain_mem [8];
	logic [31:0] chain_rd_q;
	logic [2:0]  chain_rd_addr;
	logic        chain_wr_en;
	logic [2:0]  chain_wr_addr;
	logic [31:0] chain_wr_word;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [31:0] part_q;    // bytes of the word being filled
	logic        final_q;   // current block is the last one
	logic        ending_q;  // message end in progress
	logic        init_q;    // chaining memory holds stale values, use INIT_HASH
	logic [5:0]  cnt_q;
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [2:0]  emit_q;
	logic [31:0] chain_val;
	logic [2:0]  chain_rd_addr_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			blk_mem[wr_addr] <= wr_word;
		rd_word_q <= blk_mem[rd_addr];
		if (chain_wr_en)
			chain_mem[chain_wr_addr] <= chain_wr_word;
		chain_rd_q <= chain_mem[chain_rd_addr];
	end

	assign chain_val = init_q ? INIT_HASH[chain_rd_addr_s1] : chain_rd_q;

	always_ff @(posedge clk)
		chain_rd_addr_s1 <= chain_rd_addr;

	logic        in_xfer;
	logic [31:0] merged;
	logic [31:0] pad_word;
	logic [3:0]  pad_idx;
	logic        pad_two;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		merged = part_q;
		case (fill_q[1:0])
			2'd0:    merged[31:24] = in_data.data_byte;
			2'd1:    merged[23:16] = in_data.data_byte;
			2'd2:    merged[15:8]  = in_data.data_byte;
			default: merged[7:0]   = in_data.data_byte;
		endcase
	end

	// padding pass writes word cnt_q; pad starts at byte fill_q
	assign pad_idx = cnt_q[3:0];
	assign pad_two = (fill_q >= 6'(LEN_POS));
	always_comb begin
		pad_word = 32'h0;
		if (final_q && pad_idx == 4'd14)
			pad_word = bits_q[63:32];
		else if (final_q && pad_idx == 4'd15)
			pad_word = bits_q[31:0];
		else if (pad_idx == fill_q[5:2] && !(final_q && pad_two)) begin
			case (fill_q[1:0])
				2'd0:    pad_word = {PAD_MARK, 24'h0};
				2'd1:    pad_word = {part_q[31:24], PAD_MARK, 16'h0};
				2'd2:    pad_word = {part_q[31:16], PAD_MARK, 8'h0};
				default: pad_word = {part_q[31:8], PAD_MARK};
			endcase
		end
	end

	// message schedule word for round cnt_q
	logic [31:0] w_new;
	logic [31:0] w_cur;
	assign w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign w_cur = (cnt_q < 6'd16) ? w_q[cnt_q[3:0]] : w_new;

	logic [31:0] t1;
	logic [31:0] t2;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[cnt_q] + w_cur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		wr_en = 1'b0;
		wr_addr = fill_q[5:2];
		wr_word = merged;
		rd_addr = cnt_q[3:0];
		chain_rd_addr = cnt_q[2:0];
		chain_wr_en = 1'b0;
		chain_wr_addr = cnt_q[2:0] - 3'd1;
		chain_wr_word = chain_val + v_q[chain_wr_addr];
		if (in_xfer && in_data.byte_present && fill_q[1:0] == 2'd3) begin
			wr_en = 1'b1;
		end
		if (state_q == ST_PAD) begin
			wr_en = (pad_idx >= fill_q[5:2]) || (final_q && pad_two);
			wr_addr = pad_idx;
			wr_word = pad_word;
		end
		if (state_q == ST_LOAD)
			chain_rd_addr = cnt_q[2:0];
		if (state_q == ST_FOLD && cnt_q != 6'd0) begin
			chain_wr_en = 1'b1;
		end
		if (state_q == ST_EMIT || state_q == ST_WAIT)
			chain_rd_addr = emit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			final_q  <= 1'b0;
			ending_q <= 1'b0;
			init_q   <= 1'b1;
			cnt_q    <= '0;
			emit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_xfer) begin
						if (in_data.byte_present) begin
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_q + 6'd1;
						end
						if (in_data.byte_present && fill_q == 6'd63) begin
							ending_q <= in_data.last;
							state_q  <= ST_LOAD;
						end else if (in_data.last) begin
							ending_q <= 1'b1;
							final_q  <= ~((in_data.byte_present ? fill_q + 6'd1 : fill_q)
								>= 6'(LEN_POS));
							state_q  <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd15) begin
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q != 6'd0)
						w_q[cnt_q[3:0] - 4'd1] <= rd_word_q;
					if (cnt_q >= 6'd1 && cnt_q <= 6'd8)
						v_q[cnt_q[2:0] - 3'd1] <= chain_val;
					if (cnt_q == 6'd16) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					if (cnt_q >= 6'd16) begin
						for (int i = 0; i < 15; i++)
							w_q[i] <= w_q[i + 1];
						w_q[15] <= w_new;
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						cnt_q   <= '0;
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd8) begin
						cnt_q  <= '0;
						init_q <= 1'b0;
						if (!ending_q)
							state_q <= ST_IDLE;
						else if (final_q) begin
							emit_q  <= '0;
							state_q <= ST_WAIT;
						end else begin
							final_q <= 1'b1;
							state_q <= ST_PAD;
						end
					end
				end
				ST_WAIT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_ready) begin
						emit_q  <= emit_q + 3'd1;
						state_q <= ST_WAIT;
						if (emit_q == 3'd7) begin
							state_q  <= ST_IDLE;
							fill_q   <= '0;
							bits_q   <= '0;
							final_q  <= 1'b0;
							ending_q <= 1'b0;
							init_q   <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// part word: the bytes already taken within the current word
	always_ff @(posedge clk)
		if (in_xfer && in_data.byte_present)
			part_q <= merged;

	assign out_valid = (state_q == ST_EMIT);
	assign out_data.digest_word = chain_val;
	assign out_data.word_index  = emit_q;
	assign out_data.digest_done = (emit_q == 3'd7);

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input ready while digest pending");
	a_emit_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(emit_q))
		else $error("digest index moved under stall");
	a_round_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && cnt_q == 6'd63) |=> state_q == ST_FOLD)
		else $error("round count did not reach fold");
	a_fold_back: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_ready && emit_q == 3'd7) |=> fill_q == 6'd0 && init_q)
		else $error("state not restored after digest");

endmodule
